// ===== design/box_filter_3x3_mean_macros.svh =====
// assertion macros
`ifndef BOX_FILTER_3X3_MEAN_MACROS_SVH
`define BOX_FILTER_3X3_MEAN_MACROS_SVH

`ifndef SYNTH

`define BF3M_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define BF3M_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BF3M_ASSERT_IMPLIES(lbl, ante, cons)

`define BF3M_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/bf3m_pkg.sv =====
package bf3m_pkg;

  localparam int PIXEL_W   = 15;
  localparam int SUM_W     = 19;
  localparam int MEAN_W    = 19;
  localparam int ROW_W     = 16;
  localparam int COL_OUT_W = 12;
  localparam int IMG_W_W   = 13;
  localparam int IMG_H_W   = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_MAX_WIDTH = 4096;

  localparam logic [IMG_W_W-1:0] RESET_IMAGE_WIDTH  = 13'd4096;
  localparam logic [IMG_H_W-1:0] RESET_IMAGE_HEIGHT = 16'd4096;

  // divide by nine as multiply by ceil(2^26 / 9), exact for dividends below 2^23
  localparam int DIV_IN_W  = SUM_W + 4;
  localparam int DIV_SHIFT = 26;
  localparam logic [DIV_IN_W-1:0] DIV9_MULT = 23'd7456541;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 4'd0,
    REG_IMAGE_HEIGHT = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               frame_start;
  } pix_req_t;

  typedef struct packed {
    logic [MEAN_W-1:0]    mean_value;
    logic [ROW_W-1:0]     center_row;
    logic [COL_OUT_W-1:0] center_col;
    logic                 last_in_frame;
  } mean_req_t;

  typedef struct packed {
    logic has_res;
    logic last;
  } pos_flags_t;

endpackage

// ===== design/bf3m_pos_ctrl.sv =====
module bf3m_pos_ctrl
  import bf3m_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int CW = $clog2(MAX_WIDTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               frame_start,
  input  logic [IMG_W_W-1:0] image_width,
  input  logic [IMG_H_W-1:0] image_height,
  output logic [CW-1:0]      col,
  output logic [ROW_W-1:0]   row,
  output pos_flags_t         flags
);

  localparam int EW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [EW-1:0]    w_cfg;
  logic [EW-1:0]    w_eff;
  logic [IMG_H_W-1:0] h_eff;
  logic             col_wrap;
  logic             row_wrap;

  always_comb begin
    w_cfg = EW'(image_width);
    if (w_cfg < EW'(3)) begin
      w_eff = EW'(3);
    end else if (w_cfg > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    h_eff = (image_height < IMG_H_W'(3)) ? IMG_H_W'(3) : image_height;
  end

  assign col = frame_start ? '0 : col_count;
  assign row = frame_start ? '0 : row_count;

  assign col_wrap = (EW'(col) + EW'(1)) >= w_eff;
  assign row_wrap = ((ROW_W + 1)'(row) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(h_eff);

  assign flags.has_res = (row >= ROW_W'(2)) && (col >= CW'(2));
  assign flags.last    = (row == h_eff - IMG_H_W'(1)) && (EW'(col) == w_eff - EW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row + ROW_W'(1);
      end else begin
        col_count <= col + CW'(1);
        row_count <= row;
      end
    end
  end

endmodule

// ===== design/bf3m_line_store.sv =====
module bf3m_line_store
  import bf3m_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int CW = $clog2(MAX_WIDTH)
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [CW-1:0]      rd_col,
  input  logic               wr_en,
  input  logic [CW-1:0]      wr_col,
  input  logic [PIXEL_W-1:0] wr_one,
  input  logic [PIXEL_W-1:0] wr_two,
  output logic [PIXEL_W-1:0] top,
  output logic [PIXEL_W-1:0] mid
);

  logic [PIXEL_W-1:0] mem_one [MAX_WIDTH];
  logic [PIXEL_W-1:0] mem_two [MAX_WIDTH];
  logic [PIXEL_W-1:0] rd_one;
  logic [PIXEL_W-1:0] rd_two;
  logic               fwd;
  logic [PIXEL_W-1:0] fwd_one;
  logic [PIXEL_W-1:0] fwd_two;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_one[wr_col] <= wr_one;
      mem_two[wr_col] <= wr_two;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_one <= mem_one[rd_col];
      rd_two <= mem_two[rd_col];
    end
  end

  // same column written while being read: take the new values
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd     <= wr_en && (wr_col == rd_col);
      fwd_one <= wr_one;
      fwd_two <= wr_two;
    end
  end

  assign top = fwd ? fwd_two : rd_two;
  assign mid = fwd ? fwd_one : rd_one;

endmodule

// ===== design/bf3m_mean_calc.sv =====
module bf3m_mean_calc
  import bf3m_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [SUM_W-1:0]     sum,
  input  logic [ROW_W-1:0]     row,
  input  logic [COL_OUT_W-1:0] col,
  input  logic                 last,
  output logic                 free,
  output logic                 res_valid,
  input  logic                 res_stall,
  output mean_req_t            res
);

  logic                 s2_valid;
  logic [SUM_W-1:0]     s2_sum;
  logic [ROW_W-1:0]     s2_row;
  logic [COL_OUT_W-1:0] s2_col;
  logic                 s2_last;
  logic                 s2_adv;
  logic [DIV_IN_W-1:0]  dividend;
  logic [2*DIV_IN_W-1:0] prod;

  assign s2_adv = s2_valid && (!res_valid || !res_stall);
  assign free   = !s2_valid || s2_adv;

  assign dividend = {s2_sum, 4'b0000};
  assign prod     = dividend * DIV9_MULT;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (load) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_sum  <= sum;
      s2_row  <= row;
      s2_col  <= col;
      s2_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      res.mean_value    <= prod[DIV_SHIFT+MEAN_W-1:DIV_SHIFT];
      res.center_row    <= s2_row;
      res.center_col    <= s2_col;
      res.last_in_frame <= s2_last;
    end
  end

endmodule

// ===== design/box_filter_3x3_mean.sv =====
// 3x3 box filter. Takes one pixel request per clock in raster order and gives,
// for each interior pixel, the mean of its 3x3 neighborhood as unsigned fixed point
// with 4 fraction bits, floor(sum*16/9). A result comes out once the pixel below and
// to the right of the center has been taken; border pixels give none. frame_start
// restarts the row and column count; after the last pixel of a frame the count wraps
// on its own. Sustained rate is one pixel per clock while the output is not stalled;
// each result passes a line store read, a sum and a divide by nine through a multiply,
// each ending in a register. The two line stores are single memories of MAX_WIDTH
// entries, read and written once per pixel. No clearing pass is needed after reset.
`include "box_filter_3x3_mean_macros.svh"

module box_filter_3x3_mean
  import bf3m_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pix_valid,
  output logic                  pix_stall,
  input  pix_req_t              pix,
  output logic                  res_valid,
  input  logic                  res_stall,
  output mean_req_t             res
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;

  logic               accept;
  logic [CW-1:0]      a_col;
  logic [ROW_W-1:0]   a_row;
  pos_flags_t         a_flags;

  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_px;
  logic [CW-1:0]      s1_col;
  logic [ROW_W-1:0]   s1_row;
  pos_flags_t         s1_flags;
  logic               s1_adv;

  logic [PIXEL_W-1:0] top;
  logic [PIXEL_W-1:0] mid;
  logic [PIXEL_W-1:0] win [6];
  logic [SUM_W-1:0]   sum;
  logic               s2_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_IMAGE_WIDTH;
      image_height <= RESET_IMAGE_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv    = s1_valid && (!s1_flags.has_res || s2_free);
  assign pix_stall = s1_valid && !s1_adv;
  assign accept    = pix_valid && !pix_stall;

  bf3m_pos_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_pos (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .frame_start  (pix.frame_start),
    .image_width  (image_width),
    .image_height (image_height),
    .col          (a_col),
    .row          (a_row),
    .flags        (a_flags)
  );

  bf3m_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_lines (
    .clk    (clk),
    .rd_en  (accept),
    .rd_col (a_col),
    .wr_en  (s1_adv),
    .wr_col (s1_col),
    .wr_one (s1_px),
    .wr_two (mid),
    .top    (top),
    .mid    (mid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px    <= pix.pixel;
      s1_col   <= a_col;
      s1_row   <= a_row;
      s1_flags <= a_flags;
    end
  end

  // two previous columns, oldest first
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= s1_px;
    end
  end

  always_comb begin
    sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(s1_px);
    for (int i = 0; i < 6; i++) begin
      sum = sum + SUM_W'(win[i]);
    end
  end

  bf3m_mean_calc u_mean (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_adv && s1_flags.has_res),
    .sum       (sum),
    .row       (s1_row - ROW_W'(1)),
    .col       (COL_OUT_W'(s1_col - CW'(1))),
    .last      (s1_flags.last),
    .free      (s2_free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  `BF3M_ASSERT_IMPLIES(a_stall_needs_s1, pix_stall, s1_valid)
  `BF3M_ASSERT_NEXT(a_accept_loads_s1, accept, s1_valid)
  `BF3M_ASSERT_IMPLIES(a_stall_only_on_result, pix_stall, s1_flags.has_res && !s2_free)

endmodule
